FILE: rtl/byte_stream_cipher_with_key_schedule_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte stream cipher
// Shorthands for clocked concurrent assertions used by the checker.
// ----------------------------------------------------------------------------
`ifndef BYTE_STREAM_CIPHER_WITH_KEY_SCHEDULE_MACROS_SVH
`define BYTE_STREAM_CIPHER_WITH_KEY_SCHEDULE_MACROS_SVH

// checked only outside reset
`define BSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked on every edge, reset included
`define BSC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared constants, control word layout and microcode ROM of the cipher.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int TBL_DEPTH  = 256;
  localparam int TBL_AW     = 8;
  localparam int BYTE_W     = 8;
  localparam int HALF_TABLE = TBL_DEPTH / 2;
  localparam int CFG_AW     = 6;
  localparam int CFG_DW     = 64;
  localparam int WORD_BYTES = CFG_DW / 8;
  localparam int KEY_WORDS  = 4;
  localparam int KEY_IDX_W  = 5;   // key byte index, up to 32 key bytes
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_KEY0  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY1  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY2  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY3  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NONCE = 3'd4;

  // request kind carried in tuser
  typedef enum logic {REQ_REKEY = 1'b0, REQ_DATA = 1'b1} req_t;

  typedef logic [KEY_WORDS-1:0][WORD_BYTES-1:0][BYTE_W-1:0] key_bytes_t;
  typedef logic [WORD_BYTES-1:0][BYTE_W-1:0]                word_bytes_t;

  typedef enum logic [4:0] {
    S_RST, S_IDLE, S_CLR, S_KEY,
    S_SPA0, S_SPA1, S_NON0, S_NON1, S_SPB0, S_SPB1,
    S_MX0, S_MX1, S_MX2, S_HF0, S_HF1, S_HF2, S_END,
    S_DAT0, S_DAT1, S_DAT2
  } step_t;

  typedef enum logic [2:0] {
    A_CNT, A_KEYP, A_NXT, A_DST, A_HALF, A_POS, A_POS1
  } addr_sel_t;

  typedef enum logic [2:0] {
    WD_ZERO, WD_KEY, WD_NONCE, WD_ACC, WD_SUM3
  } wd_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_CLR, ACC_ADD_WD, ACC_ADD_WD_CNT, ACC_ADD_TMP_CNT, ACC_ADD_WD_POS
  } acc_op_t;

  typedef enum logic [1:0] {POS_HOLD, POS_CLR, POS_INC} pos_op_t;

  typedef enum logic [1:0] {L_FULL, L_KEY, L_NONCE, L_SPAN} lim_sel_t;

  typedef enum logic [2:0] {
    BR_NEXT, BR_LOOP, BR_IDLE, BR_DISPATCH, BR_WAIT_OUT
  } br_t;

  typedef struct packed {
    logic      ram_we;
    addr_sel_t addr_sel;
    wd_sel_t   wd_sel;
    acc_op_t   acc_op;
    logic      tmp_ld;
    logic      cnt_inc;
    pos_op_t   pos_op;
    logic      out_ld;
    lim_sel_t  lim_sel;
    br_t       br;
    step_t     tgt;
  } ctl_word_t;

  typedef struct packed {
    logic cnt_last;
  } dp_stat_t;

  // Microcode ROM. A loop step falls through to the next step on its last pass.
  function automatic ctl_word_t ucode(step_t s);
    ctl_word_t w;
    w = '0;
    case (s)
      S_RST, S_CLR: begin
        w.ram_we  = 1'b1;
        w.wd_sel  = WD_ZERO;
        w.acc_op  = ACC_CLR;
        w.pos_op  = POS_CLR;
        w.cnt_inc = 1'b1;
        w.lim_sel = L_FULL;
        w.br      = BR_LOOP;
        w.tgt     = s;
      end
      S_IDLE: w.br = BR_DISPATCH;
      S_KEY: begin
        // table was just cleared, so the entry is the key byte itself
        w.ram_we  = 1'b1;
        w.wd_sel  = WD_KEY;
        w.acc_op  = ACC_ADD_WD;
        w.cnt_inc = 1'b1;
        w.lim_sel = L_KEY;
        w.br      = BR_LOOP;
        w.tgt     = S_KEY;
      end
      S_SPA0, S_SPB0: w.addr_sel = A_KEYP;
      S_SPA1, S_SPB1: begin
        w.ram_we   = 1'b1;
        w.addr_sel = A_KEYP;
        w.wd_sel   = WD_ACC;
        w.acc_op   = ACC_ADD_WD_CNT;
        w.cnt_inc  = 1'b1;
        w.lim_sel  = L_FULL;
        w.br       = BR_LOOP;
        w.tgt      = (s == S_SPA1) ? S_SPA0 : S_SPB0;
      end
      S_NON0: w.addr_sel = A_CNT;
      S_NON1: begin
        w.ram_we  = 1'b1;
        w.wd_sel  = WD_NONCE;
        w.acc_op  = ACC_ADD_WD;
        w.cnt_inc = 1'b1;
        w.lim_sel = L_NONCE;
        w.br      = BR_LOOP;
        w.tgt     = S_NON0;
      end
      S_MX0: w.addr_sel = A_CNT;
      S_MX1: begin
        w.addr_sel = A_NXT;
        w.tmp_ld   = 1'b1;
      end
      S_MX2: begin
        w.ram_we   = 1'b1;
        w.addr_sel = A_DST;
        w.wd_sel   = WD_SUM3;
        w.acc_op   = ACC_ADD_TMP_CNT;
        w.cnt_inc  = 1'b1;
        w.lim_sel  = L_SPAN;
        w.br       = BR_LOOP;
        w.tgt      = S_MX0;
      end
      S_HF0: w.addr_sel = A_CNT;
      S_HF1: begin
        w.addr_sel = A_HALF;
        w.tmp_ld   = 1'b1;
      end
      S_HF2: begin
        w.ram_we   = 1'b1;
        w.addr_sel = A_CNT;
        w.wd_sel   = WD_SUM3;
        w.acc_op   = ACC_ADD_WD_CNT;
        w.cnt_inc  = 1'b1;
        w.lim_sel  = L_FULL;
        w.br       = BR_LOOP;
        w.tgt      = S_HF0;
      end
      S_END: w.br = BR_IDLE;
      S_DAT0: begin
        w.addr_sel = A_POS;
        w.br       = BR_WAIT_OUT;
      end
      S_DAT1: begin
        w.addr_sel = A_POS1;
        w.tmp_ld   = 1'b1;
      end
      S_DAT2: begin
        w.ram_we   = 1'b1;
        w.addr_sel = A_POS;
        w.wd_sel   = WD_SUM3;
        w.acc_op   = ACC_ADD_WD_POS;
        w.pos_op   = POS_INC;
        w.out_ld   = 1'b1;
        w.br       = BR_IDLE;
      end
      default: w.br = BR_IDLE;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/bsc_ram.sv
// ----------------------------------------------------------------------------
// bsc_ram
// Generic single-port RAM, one read or write per cycle, registered read.
// ----------------------------------------------------------------------------
module bsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bsc_useq.sv
// ----------------------------------------------------------------------------
// bsc_useq
// Microcode sequencer: step counter, ROM fetch and branch logic.
// ----------------------------------------------------------------------------
module bsc_useq (
  input  logic               clk,
  input  logic               rst_n,
  input  bsc_pkg::dp_stat_t  stat,
  input  logic               in_fire,
  input  logic               in_req,
  input  logic               out_busy,
  output bsc_pkg::ctl_word_t ctl,
  output logic               in_ready
);

  bsc_pkg::step_t pc_r;
  bsc_pkg::step_t pc_nxt;
  bsc_pkg::step_t pc_inc;

  assign ctl      = bsc_pkg::ucode(pc_r);
  assign in_ready = (pc_r == bsc_pkg::S_IDLE);
  assign pc_inc   = bsc_pkg::step_t'(pc_r + 5'd1);

  always_comb begin
    case (ctl.br)
      bsc_pkg::BR_NEXT:     pc_nxt = pc_inc;
      bsc_pkg::BR_LOOP:     pc_nxt = stat.cnt_last ? pc_inc : ctl.tgt;
      bsc_pkg::BR_IDLE:     pc_nxt = bsc_pkg::S_IDLE;
      bsc_pkg::BR_DISPATCH: begin
        if (in_fire) begin
          pc_nxt = (in_req == bsc_pkg::REQ_DATA) ? bsc_pkg::S_DAT0 : bsc_pkg::S_CLR;
        end else begin
          pc_nxt = bsc_pkg::S_IDLE;
        end
      end
      bsc_pkg::BR_WAIT_OUT: pc_nxt = out_busy ? pc_r : pc_inc;
      default:              pc_nxt = bsc_pkg::S_IDLE;
    endcase
  end

  // reset starts the clearing pass over the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= bsc_pkg::S_RST;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: rtl/bsc_dpath.sv
// ----------------------------------------------------------------------------
// bsc_dpath
// Datapath: table RAM, accumulator, position, loop counters and byte adders.
// ----------------------------------------------------------------------------
module bsc_dpath #(
  parameter int KEY_BYTES   = 32,
  parameter int NONCE_BYTES = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bsc_pkg::ctl_word_t         ctl,
  input  bsc_pkg::key_bytes_t        key_bytes,
  input  bsc_pkg::word_bytes_t       nonce_bytes,
  input  logic [bsc_pkg::BYTE_W-1:0] data_byte,
  output bsc_pkg::dp_stat_t          stat,
  output logic [bsc_pkg::BYTE_W-1:0] result
);

  localparam int AW = bsc_pkg::TBL_AW;
  localparam int BW = bsc_pkg::BYTE_W;
  localparam int KW = bsc_pkg::KEY_IDX_W;

  localparam logic [AW-1:0] FULL_LAST  = AW'(bsc_pkg::TBL_DEPTH - 1);
  localparam logic [AW-1:0] KEY_LAST   = AW'(KEY_BYTES - 1);
  localparam logic [AW-1:0] NONCE_LAST = AW'(NONCE_BYTES - 1);
  localparam logic [AW-1:0] SPAN_LAST  = AW'(bsc_pkg::TBL_DEPTH - KEY_BYTES - 1);
  localparam logic [AW-1:0] KEY_OFF    = AW'(KEY_BYTES);
  localparam logic [AW-1:0] HALF_OFF   = AW'(bsc_pkg::HALF_TABLE);
  localparam logic [KW-1:0] KEYP_LAST  = KW'(KEY_BYTES - 1);

  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [KW-1:0] keyp_r, keyp_nxt;   // counter mod KEY_BYTES
  logic [BW-1:0] acc_r, acc_nxt;
  logic [BW-1:0] pos_r, pos_nxt;
  logic [BW-1:0] tmp_r;
  logic [AW-1:0] addr;
  logic [BW-1:0] wd;
  logic [BW-1:0] rd;
  logic [BW-1:0] ks;
  logic          last;

  always_comb begin
    case (ctl.lim_sel)
      bsc_pkg::L_FULL:  last = (cnt_r == FULL_LAST);
      bsc_pkg::L_KEY:   last = (cnt_r == KEY_LAST);
      bsc_pkg::L_NONCE: last = (cnt_r == NONCE_LAST);
      bsc_pkg::L_SPAN:  last = (cnt_r == SPAN_LAST);
      default:          last = 1'b1;
    endcase
  end

  assign stat.cnt_last = last;

  always_comb begin
    case (ctl.addr_sel)
      bsc_pkg::A_CNT:  addr = cnt_r;
      bsc_pkg::A_KEYP: addr = AW'(keyp_r);
      bsc_pkg::A_NXT:  addr = (cnt_r == SPAN_LAST) ? '0 : AW'(cnt_r + 1'b1);
      bsc_pkg::A_DST:  addr = AW'(cnt_r + KEY_OFF);
      bsc_pkg::A_HALF: addr = AW'(cnt_r + HALF_OFF);
      bsc_pkg::A_POS:  addr = pos_r;
      bsc_pkg::A_POS1: addr = AW'(pos_r + 1'b1);
      default:         addr = cnt_r;
    endcase
  end

  always_comb begin
    case (ctl.wd_sel)
      bsc_pkg::WD_ZERO:  wd = '0;
      bsc_pkg::WD_KEY:   wd = key_bytes[cnt_r[4:3]][cnt_r[2:0]];
      bsc_pkg::WD_NONCE: wd = BW'(rd + nonce_bytes[cnt_r[2:0]]);
      bsc_pkg::WD_ACC:   wd = BW'(rd + acc_r);
      bsc_pkg::WD_SUM3:  wd = BW'(tmp_r + rd + acc_r);
      default:           wd = '0;
    endcase
  end

  always_comb begin
    case (ctl.acc_op)
      bsc_pkg::ACC_HOLD:        acc_nxt = acc_r;
      bsc_pkg::ACC_CLR:         acc_nxt = '0;
      bsc_pkg::ACC_ADD_WD:      acc_nxt = BW'(acc_r + wd);
      bsc_pkg::ACC_ADD_WD_CNT:  acc_nxt = BW'(acc_r + wd + cnt_r);
      bsc_pkg::ACC_ADD_TMP_CNT: acc_nxt = BW'(acc_r + tmp_r + cnt_r);
      bsc_pkg::ACC_ADD_WD_POS:  acc_nxt = BW'(acc_r + wd + pos_r);
      default:                  acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    case (ctl.pos_op)
      bsc_pkg::POS_HOLD: pos_nxt = pos_r;
      bsc_pkg::POS_CLR:  pos_nxt = '0;
      bsc_pkg::POS_INC:  pos_nxt = BW'(pos_r + 1'b1);
      default:           pos_nxt = pos_r;
    endcase
  end

  // counters return to zero when a loop finishes
  always_comb begin
    cnt_nxt  = cnt_r;
    keyp_nxt = keyp_r;
    if (ctl.cnt_inc) begin
      if (last) begin
        cnt_nxt  = '0;
        keyp_nxt = '0;
      end else begin
        cnt_nxt  = AW'(cnt_r + 1'b1);
        keyp_nxt = (keyp_r == KEYP_LAST) ? '0 : KW'(keyp_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      keyp_r <= '0;
      acc_r  <= '0;
      pos_r  <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      keyp_r <= keyp_nxt;
      acc_r  <= acc_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tmp_ld) begin
      tmp_r <= rd;
    end
  end

  bsc_ram #(
    .WIDTH (BW),
    .DEPTH (bsc_pkg::TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ctl.ram_we),
    .addr  (addr),
    .wdata (wd),
    .rdata (rd)
  );

  // keystream from the updated accumulator and the new table entry
  assign ks     = BW'(acc_nxt + wd) ^ wd;
  assign result = data_byte ^ ks;

endmodule

FILE: rtl/byte_stream_cipher_with_key_schedule.sv
// ----------------------------------------------------------------------------
// byte_stream_cipher_with_key_schedule
// Byte stream cipher with a 256-entry table and a microcoded key schedule.
// ----------------------------------------------------------------------------
// Data byte: accepted only in S_IDLE; S_DAT0, S_DAT1 and S_DAT2 then make two
//   reads and one write of the single-port table before the next is taken.
// Rekey: runs the table sweeps of the schedule, with one table access per
//   cycle.
// Reset: synchronous; a clearing pass zeroes the table while in_tready is
//   low. Config writes are taken at any time.
module byte_stream_cipher_with_key_schedule #(
  parameter int KEY_BYTES   = 32,
  parameter int NONCE_BYTES = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] data_in
  input  logic                       in_tuser,   // [0] req_type
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,  // [7:0] data_out
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bsc_pkg::CFG_AW-1:0] paddr,
  input  logic [bsc_pkg::CFG_DW-1:0] pwdata,
  output logic [bsc_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);

  bsc_pkg::key_bytes_t  key_r;
  bsc_pkg::word_bytes_t nonce_r;
  logic [bsc_pkg::REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  bsc_pkg::ctl_word_t   ctl;
  bsc_pkg::dp_stat_t    stat;
  logic                 in_fire;
  logic                 out_busy;
  logic [7:0]           data_r;
  logic [7:0]           result;
  logic                 out_valid_r;
  logic [7:0]           out_data_r;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[bsc_pkg::CFG_AW-1:3];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      nonce_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        bsc_pkg::REG_KEY0:  key_r[0] <= pwdata;
        bsc_pkg::REG_KEY1:  key_r[1] <= pwdata;
        bsc_pkg::REG_KEY2:  key_r[2] <= pwdata;
        bsc_pkg::REG_KEY3:  key_r[3] <= pwdata;
        bsc_pkg::REG_NONCE: nonce_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bsc_pkg::REG_KEY0:  prdata = key_r[0];
      bsc_pkg::REG_KEY1:  prdata = key_r[1];
      bsc_pkg::REG_KEY2:  prdata = key_r[2];
      bsc_pkg::REG_KEY3:  prdata = key_r[3];
      bsc_pkg::REG_NONCE: prdata = nonce_r;
      default:            prdata = '0;
    endcase
  end

  // input side
  assign in_fire  = in_tvalid & in_tready;
  assign out_busy = out_valid_r & ~out_tready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      data_r <= in_tdata;
    end
  end

  bsc_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .in_fire  (in_fire),
    .in_req   (in_tuser),
    .out_busy (out_busy),
    .ctl      (ctl),
    .in_ready (in_tready)
  );

  bsc_dpath #(
    .KEY_BYTES   (KEY_BYTES),
    .NONCE_BYTES (NONCE_BYTES)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .key_bytes   (key_r),
    .nonce_bytes (nonce_r),
    .data_byte   (data_r),
    .stat        (stat),
    .result      (result)
  );

  // output register; the sequencer holds before reading if it is still full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_ld) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/bsc_checker.sv
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks on the cipher, bound to the top level.
// ----------------------------------------------------------------------------
`include "byte_stream_cipher_with_key_schedule_macros.svh"

module bsc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // reset starts the clearing pass: nothing accepted, nothing shown
  `BSC_ASSERT_RST(a_reset_quiet, (!rst_n |=> !in_tready && !out_tvalid), "busy or valid after reset")

  // a waiting result holds
  `BSC_ASSERT(a_out_hold, (out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)), "output changed while stalled")

  // one transaction at a time
  `BSC_ASSERT(a_busy_after_accept, (in_tvalid && in_tready |=> !in_tready), "ready right after accept")

  // a rekey never produces a result
  `BSC_ASSERT(a_rekey_silent, (in_tvalid && in_tready && !in_tuser && !out_tvalid |=> !out_tvalid), "result from rekey")

  // a data byte accepted with a free output slot shows its result
  `BSC_ASSERT(a_data_latency, (in_tvalid && in_tready && in_tuser && !out_tvalid |-> ##4 out_tvalid), "data result late")

endmodule

bind byte_stream_cipher_with_key_schedule bsc_checker u_bsc_checker (.*);
